FILE: design/umsc_pkg.sv
// umsc_pkg: types and constants of the mass-storage bulk-only transport block
// used by usb_msc_bulk_only_transport_fsm and umsc_checker, no dependencies
`timescale 1ns / 1ps
package umsc_pkg;

   typedef enum logic [1:0] {
      OP_OUT   = 2'd0,
      OP_IN    = 2'd1,
      OP_SETUP = 2'd2,
      OP_SPARE = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ACT_NONE        = 4'd0,
      ACT_ARM_CBW     = 4'd1,
      ACT_SEND_DATA   = 4'd2,
      ACT_SEND_CSW    = 4'd3,
      ACT_STALL_OUT   = 4'd4,
      ACT_STALL_BOTH  = 4'd5,
      ACT_SETUP_DATA  = 4'd6,
      ACT_SETUP_EMPTY = 4'd7,
      ACT_UNHANDLED   = 4'd8
   } action_type;

   typedef enum logic [1:0] {
      SRC_INQUIRY  = 2'd0,
      SRC_CAPACITY = 2'd1,
      SRC_ZERO     = 2'd2
   } source_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_DIN  = 3'd1,
      PH_DOUT = 3'd2,
      PH_CSW  = 3'd3,
      PH_ERR  = 3'd4
   } phase_type;

   typedef struct packed {
      action_type  action;
      logic [1:0]  data_source;
      logic [5:0]  send_length;
      logic        csw_status;
      logic [31:0] csw_residue;
      logic [31:0] csw_tag;
      logic        last;
   } rsp_type;

   localparam logic [31:0] CBW_SIGNATURE = 32'h4342_5355;
   localparam logic [9:0]  CBW_LENGTH    = 10'd31;
   localparam logic [7:0]  OPC_SENSE     = 8'h03;
   localparam logic [7:0]  OPC_INQUIRY   = 8'h12;
   localparam logic [7:0]  OPC_RFC       = 8'h23;
   localparam logic [5:0]  INQUIRY_LEN   = 6'd36;
   localparam logic [5:0]  RFC_LEN       = 6'd12;
   localparam logic [5:0]  LUN_LEN       = 6'd1;
   localparam logic [6:0]  CLASS_IFACE   = 7'h21;
   localparam logic [7:0]  REQ_MAX_LUN   = 8'hFE;
   localparam logic [7:0]  REQ_MSC_RESET = 8'hFF;
   localparam int unsigned FLAG_DIR_BIT  = 7;

endpackage

FILE: design/usb_msc_bulk_only_transport_fsm.sv
// usb_msc_bulk_only_transport_fsm: device-side bulk-only transport control, uses umsc_pkg
// a result word is registered and valid in the cycle after its event is accepted
// throughput: one event per cycle unless a result word is stalled or queued;
// a mass-storage reset gives two words, and req_ready is low while the second is queued
// reset: synchronous, clears phase to idle with CBW receive armed, kept
// tag, residue and status to zero, and empties the result register
`timescale 1ns / 1ps
module usb_msc_bulk_only_transport_fsm (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [9:0]  req_rx_length,
   input  logic [31:0] req_cbw_signature,
   input  logic [31:0] req_cbw_tag,
   input  logic [31:0] req_cbw_transfer_length,
   input  logic [7:0]  req_cbw_flags,
   input  logic [7:0]  req_scsi_opcode,
   input  logic [7:0]  req_setup_type,
   input  logic [7:0]  req_setup_request,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_action,
   output logic [1:0]  rsp_data_source,
   output logic [5:0]  rsp_send_length,
   output logic        rsp_csw_status,
   output logic [31:0] rsp_csw_residue,
   output logic [31:0] rsp_csw_tag,
   output logic        rsp_last
);
   import umsc_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [31:0] tag_ff, tag_in;
   logic [31:0] residue_ff, residue_in;
   logic        status_ff, status_in;

   rsp_type     out_ff, out_in;
   logic        out_valid_ff, out_valid_in;
   rsp_type     pend_ff, pend_in;
   logic        pend_valid_ff, pend_valid_in;

   rsp_type     first_rsp;
   logic        two_rsp;
   logic [5:0]  full_len;
   logic [5:0]  clamp_len;
   logic [1:0]  src;
   logic        data_cmd;
   logic        tl_zero;
   logic        accept;

   assign req_ready = !pend_valid_ff && (!out_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign tl_zero   = (req_cbw_transfer_length == 32'd0);

   // clamp of the reply length to the host transfer length
   always_comb begin
      data_cmd = 1'b1;
      full_len = INQUIRY_LEN;
      src      = SRC_INQUIRY;
      case (req_scsi_opcode)
         OPC_INQUIRY: begin
            full_len = INQUIRY_LEN;
            src      = SRC_INQUIRY;
         end
         OPC_RFC: begin
            full_len = RFC_LEN;
            src      = SRC_CAPACITY;
         end
         default: begin
            data_cmd = 1'b0;
         end
      endcase
      if (req_cbw_transfer_length < {26'd0, full_len}) begin
         clamp_len = req_cbw_transfer_length[5:0];
      end else begin
         clamp_len = full_len;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      tag_in     = tag_ff;
      residue_in = residue_ff;
      status_in  = status_ff;
      two_rsp    = 1'b0;
      first_rsp  = '{action: ACT_NONE, data_source: 2'd0, send_length: 6'd0,
                     csw_status: 1'b0, csw_residue: 32'd0, csw_tag: 32'd0,
                     last: 1'b1};
      case (op_type'(req_op))
         OP_OUT: begin
            if (phase_ff != PH_IDLE) begin
               first_rsp.action = ACT_NONE;
            end else if (req_rx_length != CBW_LENGTH
                         || req_cbw_signature != CBW_SIGNATURE) begin
               phase_in         = PH_ERR;
               first_rsp.action = ACT_STALL_OUT;
            end else begin
               tag_in = req_cbw_tag;
               if (req_scsi_opcode == OPC_SENSE) begin
                  status_in        = 1'b0;
                  residue_in       = req_cbw_transfer_length;
                  phase_in         = PH_CSW;
                  first_rsp.action = ACT_SEND_CSW;
               end else if (!data_cmd) begin
                  if (tl_zero) begin
                     status_in        = 1'b1;
                     residue_in       = 32'd0;
                     phase_in         = PH_CSW;
                     first_rsp.action = ACT_SEND_CSW;
                  end else begin
                     phase_in         = PH_ERR;
                     first_rsp.action = ACT_STALL_BOTH;
                  end
               end else if (tl_zero) begin
                  status_in        = 1'b0;
                  residue_in       = 32'd0;
                  phase_in         = PH_CSW;
                  first_rsp.action = ACT_SEND_CSW;
               end else begin
                  status_in  = 1'b0;
                  residue_in = req_cbw_transfer_length - {26'd0, clamp_len};
                  if (req_cbw_flags[FLAG_DIR_BIT]) begin
                     phase_in = PH_DIN;
                  end else begin
                     phase_in = PH_DOUT;
                  end
                  first_rsp.action      = ACT_SEND_DATA;
                  first_rsp.data_source = src;
                  first_rsp.send_length = clamp_len;
               end
            end
         end
         OP_IN: begin
            case (phase_ff)
               PH_DIN: begin
                  phase_in         = PH_CSW;
                  first_rsp.action = ACT_SEND_CSW;
               end
               PH_CSW: begin
                  phase_in         = PH_IDLE;
                  first_rsp.action = ACT_ARM_CBW;
               end
               default: begin
                  first_rsp.action = ACT_NONE;
               end
            endcase
         end
         OP_SETUP: begin
            first_rsp.action = ACT_UNHANDLED;
            if (req_setup_type[6:0] == CLASS_IFACE) begin
               if (req_setup_request == REQ_MAX_LUN) begin
                  first_rsp.action      = ACT_SETUP_DATA;
                  first_rsp.data_source = SRC_ZERO;
                  first_rsp.send_length = LUN_LEN;
               end else if (req_setup_request == REQ_MSC_RESET) begin
                  phase_in         = PH_IDLE;
                  first_rsp.action = ACT_ARM_CBW;
                  first_rsp.last   = 1'b0;
                  two_rsp          = 1'b1;
               end
            end
         end
         default: begin
            first_rsp.action = ACT_NONE;
         end
      endcase
      if (first_rsp.action == ACT_SEND_CSW) begin
         first_rsp.csw_status  = status_in;
         first_rsp.csw_residue = residue_in;
         first_rsp.csw_tag     = tag_in;
      end
   end

   // result register with one queued word behind it
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = pend_valid_ff;
         out_in       = pend_ff;
         pend_valid_in = 1'b0;
      end
      if (accept) begin
         out_in        = first_rsp;
         out_valid_in  = 1'b1;
         pend_valid_in = two_rsp;
         pend_in       = '{action: ACT_SETUP_EMPTY, data_source: 2'd0,
                           send_length: 6'd0, csw_status: 1'b0,
                           csw_residue: 32'd0, csw_tag: 32'd0, last: 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         tag_ff        <= 32'd0;
         residue_ff    <= 32'd0;
         status_ff     <= 1'b0;
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff   <= phase_in;
            tag_ff     <= tag_in;
            residue_ff <= residue_in;
            status_ff  <= status_in;
         end
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      pend_ff <= pend_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_action      = out_ff.action;
   assign rsp_data_source = out_ff.data_source;
   assign rsp_send_length = out_ff.send_length;
   assign rsp_csw_status  = out_ff.csw_status;
   assign rsp_csw_residue = out_ff.csw_residue;
   assign rsp_csw_tag     = out_ff.csw_tag;
   assign rsp_last        = out_ff.last;

endmodule

FILE: design/umsc_checker.sv
// umsc_port_assert: port-level assertions for usb_msc_bulk_only_transport_fsm
// bound to usb_msc_bulk_only_transport_fsm below; depends on umsc_pkg
`timescale 1ns / 1ps
module umsc_port_assert (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  rsp_action,
   input logic [1:0]  rsp_data_source,
   input logic [5:0]  rsp_send_length,
   input logic        rsp_csw_status,
   input logic [31:0] rsp_csw_residue,
   input logic [31:0] rsp_csw_tag,
   input logic        rsp_last
);
   import umsc_pkg::*;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_action)
         && $stable(rsp_csw_residue) && $stable(rsp_last))
      else $error("result word changed while stalled");

   // csw fields only on send csw
   a_csw_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action != ACT_SEND_CSW |->
         !rsp_csw_status && rsp_csw_residue == 32'd0 && rsp_csw_tag == 32'd0)
      else $error("csw fields set outside send csw");

   // data fields only on data actions, length never above the inquiry size
   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_action == ACT_SEND_DATA || rsp_action == ACT_SETUP_DATA)
         ? (rsp_send_length <= INQUIRY_LEN && rsp_data_source != 2'd3)
         : (rsp_send_length == 6'd0 && rsp_data_source == 2'd0)))
      else $error("data fields wrong for action");

   // the arm word of a mass-storage reset is followed by setup empty
   a_reset_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=>
         rsp_valid && rsp_action == ACT_SETUP_EMPTY && rsp_last)
      else $error("second word of reset pair missing");

   // no new event while a non-final word is still out
   a_no_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("event accepted during reset pair");

endmodule

bind usb_msc_bulk_only_transport_fsm umsc_port_assert u_umsc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_action      (rsp_action),
   .rsp_data_source (rsp_data_source),
   .rsp_send_length (rsp_send_length),
   .rsp_csw_status  (rsp_csw_status),
   .rsp_csw_residue (rsp_csw_residue),
   .rsp_csw_tag     (rsp_csw_tag),
   .rsp_last        (rsp_last)
);

FILE: sim/umsc_checker.sv
// umsc_checker: watches both channels of usb_msc_bulk_only_transport_fsm,
// predicts the action words of every accepted event and compares them
// depends on umsc_pkg
`timescale 1ns / 1ps
module umsc_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [9:0]  req_rx_length,
   input  logic [31:0] req_cbw_signature,
   input  logic [31:0] req_cbw_tag,
   input  logic [31:0] req_cbw_transfer_length,
   input  logic [7:0]  req_cbw_flags,
   input  logic [7:0]  req_scsi_opcode,
   input  logic [7:0]  req_setup_type,
   input  logic [7:0]  req_setup_request,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [3:0]  rsp_action,
   input  logic [1:0]  rsp_data_source,
   input  logic [5:0]  rsp_send_length,
   input  logic        rsp_csw_status,
   input  logic [31:0] rsp_csw_residue,
   input  logic [31:0] rsp_csw_tag,
   input  logic        rsp_last,
   output int          fail_count,
   output int          pending
);
   import umsc_pkg::*;

   rsp_type     expected_actions[$];
   phase_type   bot_phase;
   logic [31:0] kept_tag;
   logic [31:0] kept_residue;
   logic        kept_status;

   function automatic rsp_type action_word(action_type act, source_type src,
                                           logic [5:0] len, logic last);
      rsp_type w;
      w = '0;
      w.action = act;
      w.last = last;
      if (act == ACT_SEND_DATA || act == ACT_SETUP_DATA) begin
         w.data_source = src;
         w.send_length = len;
      end
      if (act == ACT_SEND_CSW) begin
         w.csw_status = kept_status;
         w.csw_residue = kept_residue;
         w.csw_tag = kept_tag;
      end
      return w;
   endfunction

   task automatic predict_actions();
      logic [5:0]  full_len;
      source_type  src;
      logic [31:0] xfer_len;
      xfer_len = req_cbw_transfer_length;
      case (op_type'(req_op))
         OP_OUT: begin
            if (bot_phase != PH_IDLE) begin
               expected_actions.push_back(action_word(ACT_NONE, SRC_INQUIRY, '0, 1'b1));
            end else if (req_rx_length != CBW_LENGTH || req_cbw_signature != CBW_SIGNATURE) begin
               bot_phase = PH_ERR;
               expected_actions.push_back(action_word(ACT_STALL_OUT, SRC_INQUIRY, '0, 1'b1));
            end else begin
               kept_tag = req_cbw_tag;
               if (req_scsi_opcode == OPC_SENSE) begin
                  kept_status = 1'b0;
                  kept_residue = xfer_len;
                  bot_phase = PH_CSW;
                  expected_actions.push_back(action_word(ACT_SEND_CSW, SRC_INQUIRY, '0, 1'b1));
               end else if (req_scsi_opcode == OPC_INQUIRY || req_scsi_opcode == OPC_RFC) begin
                  src = (req_scsi_opcode == OPC_INQUIRY) ? SRC_INQUIRY : SRC_CAPACITY;
                  full_len = (req_scsi_opcode == OPC_INQUIRY) ? INQUIRY_LEN : RFC_LEN;
                  kept_status = 1'b0;
                  if (xfer_len == 0) begin
                     kept_residue = '0;
                     bot_phase = PH_CSW;
                     expected_actions.push_back(action_word(ACT_SEND_CSW, SRC_INQUIRY, '0, 1'b1));
                  end else begin
                     if (xfer_len < {26'd0, full_len})
                        full_len = xfer_len[5:0];
                     kept_residue = xfer_len - {26'd0, full_len};
                     bot_phase = req_cbw_flags[FLAG_DIR_BIT] ? PH_DIN : PH_DOUT;
                     expected_actions.push_back(action_word(ACT_SEND_DATA, src, full_len, 1'b1));
                  end
               end else if (xfer_len == 0) begin
                  kept_status = 1'b1;
                  kept_residue = '0;
                  bot_phase = PH_CSW;
                  expected_actions.push_back(action_word(ACT_SEND_CSW, SRC_INQUIRY, '0, 1'b1));
               end else begin
                  bot_phase = PH_ERR;
                  expected_actions.push_back(action_word(ACT_STALL_BOTH, SRC_INQUIRY, '0, 1'b1));
               end
            end
         end
         OP_IN: begin
            if (bot_phase == PH_DIN) begin
               bot_phase = PH_CSW;
               expected_actions.push_back(action_word(ACT_SEND_CSW, SRC_INQUIRY, '0, 1'b1));
            end else if (bot_phase == PH_CSW) begin
               bot_phase = PH_IDLE;
               expected_actions.push_back(action_word(ACT_ARM_CBW, SRC_INQUIRY, '0, 1'b1));
            end else begin
               expected_actions.push_back(action_word(ACT_NONE, SRC_INQUIRY, '0, 1'b1));
            end
         end
         OP_SETUP: begin
            if (req_setup_type[6:0] == CLASS_IFACE && req_setup_request == REQ_MAX_LUN) begin
               expected_actions.push_back(action_word(ACT_SETUP_DATA, SRC_ZERO, LUN_LEN, 1'b1));
            end else if (req_setup_type[6:0] == CLASS_IFACE &&
                         req_setup_request == REQ_MSC_RESET) begin
               bot_phase = PH_IDLE;
               expected_actions.push_back(action_word(ACT_ARM_CBW, SRC_INQUIRY, '0, 1'b0));
               expected_actions.push_back(action_word(ACT_SETUP_EMPTY, SRC_INQUIRY, '0, 1'b1));
            end else begin
               expected_actions.push_back(action_word(ACT_UNHANDLED, SRC_INQUIRY, '0, 1'b1));
            end
         end
         default: begin
            expected_actions.push_back(action_word(ACT_NONE, SRC_INQUIRY, '0, 1'b1));
         end
      endcase
   endtask

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         expected_actions.delete();
         bot_phase = PH_IDLE;
         kept_tag = '0;
         kept_residue = '0;
         kept_status = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_actions.size() == 0) begin
               fail_count++;
               $display("%0t: word expected none, actual action %0h", $time, rsp_action);
            end else begin
               want = expected_actions.pop_front();
               check_field("action", 32'(want.action), 32'(rsp_action));
               check_field("data_source", 32'(want.data_source), 32'(rsp_data_source));
               check_field("send_length", 32'(want.send_length), 32'(rsp_send_length));
               check_field("csw_status", 32'(want.csw_status), 32'(rsp_csw_status));
               check_field("csw_residue", want.csw_residue, rsp_csw_residue);
               check_field("csw_tag", want.csw_tag, rsp_csw_tag);
               check_field("last", 32'(want.last), 32'(rsp_last));
            end
         end
         if (req_valid && req_ready)
            predict_actions();
      end
      pending <= expected_actions.size();
   end

endmodule

FILE: sim/usb_msc_bulk_only_transport_fsm_tb.sv
// usb_msc_bulk_only_transport_fsm_tb: directed and random bulk-only transport
// events under several idle and stall mixes, checked by umsc_checker
// depends on umsc_pkg, umsc_checker and usb_msc_bulk_only_transport_fsm
`timescale 1ns / 1ps
module usb_msc_bulk_only_transport_fsm_tb;
   import umsc_pkg::*;

   localparam int EVENTS_PER_MIX = 465;
   localparam int HOLD_CYCLES    = 300;
   localparam int QUIET_LIMIT    = 5000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_op = '0;
   logic [9:0]  req_rx_length = '0;
   logic [31:0] req_cbw_signature = '0;
   logic [31:0] req_cbw_tag = '0;
   logic [31:0] req_cbw_transfer_length = '0;
   logic [7:0]  req_cbw_flags = '0;
   logic [7:0]  req_scsi_opcode = '0;
   logic [7:0]  req_setup_type = '0;
   logic [7:0]  req_setup_request = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_action;
   logic [1:0]  rsp_data_source;
   logic [5:0]  rsp_send_length;
   logic        rsp_csw_status;
   logic [31:0] rsp_csw_residue;
   logic [31:0] rsp_csw_tag;
   logic        rsp_last;

   int fail_count;
   int pending;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int sent_count = 0;
   int quiet_cycles = 0;
   bit hold_request = 1'b0;
   bit left_stuck = 1'b1;

   usb_msc_bulk_only_transport_fsm u_dut (.*);

   umsc_checker u_checker (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   task automatic send_word(input op_type op, input logic [9:0] rx,
                            input logic [31:0] sig, input logic [31:0] tag,
                            input logic [31:0] xfer_len, input logic [7:0] flags,
                            input logic [7:0] opc, input logic [7:0] stype,
                            input logic [7:0] sreq);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_rx_length <= rx;
      req_cbw_signature <= sig;
      req_cbw_tag <= tag;
      req_cbw_transfer_length <= xfer_len;
      req_cbw_flags <= flags;
      req_scsi_opcode <= opc;
      req_setup_type <= stype;
      req_setup_request <= sreq;
      do @(posedge clock); while (!req_ready);
      sent_count++;
   endtask

   task automatic send_cbw(input logic [7:0] opc, input logic [31:0] xfer_len,
                           input logic [7:0] flags);
      send_word(OP_OUT, CBW_LENGTH, CBW_SIGNATURE, $urandom, xfer_len, flags, opc,
                8'($urandom), 8'($urandom));
   endtask

   task automatic send_in();
      send_word(OP_IN, 10'($urandom_range(1023)), $urandom, $urandom, $urandom,
                8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic send_setup(input logic [7:0] stype, input logic [7:0] sreq);
      send_word(OP_SETUP, 10'($urandom_range(1023)), $urandom, $urandom, $urandom,
                8'($urandom), 8'($urandom), stype, sreq);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // class interface request type, direction bit random
   function automatic logic [7:0] iface_type_byte();
      return {$urandom_range(1) == 1, CLASS_IFACE};
   endfunction

   function automatic logic [31:0] pick_length();
      case ($urandom_range(9))
         0:       return '0;
         1, 2, 3: return $urandom_range(40);
         4:       return 32'd12;
         5:       return 32'd36;
         6:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [7:0] pick_opcode();
      case ($urandom_range(9))
         0, 1, 2: return OPC_INQUIRY;
         3, 4:    return OPC_RFC;
         5, 6:    return OPC_SENSE;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic random_flow();
      logic [7:0]  opc;
      logic [31:0] xfer_len;
      logic [7:0]  flags;
      int          in_count;
      opc = pick_opcode();
      xfer_len = pick_length();
      flags = 8'($urandom);
      if ($urandom_range(9) < 8)
         flags[FLAG_DIR_BIT] = 1'b1;
      if ($urandom_range(99) < 70) begin
         if (left_stuck || $urandom_range(9) == 0)
            send_setup(iface_type_byte(), REQ_MSC_RESET);
         if ($urandom_range(9) == 0)
            send_setup(iface_type_byte(), REQ_MAX_LUN);
         send_cbw(opc, xfer_len, flags);
         in_count = ($urandom_range(9) == 0) ? $urandom_range(3) : 2;
         repeat (in_count) send_in();
         left_stuck = (in_count < 2) ||
                      (xfer_len != 0 && opc != OPC_SENSE &&
                       !(flags[FLAG_DIR_BIT] && (opc == OPC_INQUIRY || opc == OPC_RFC)));
      end else begin
         send_word(op_type'($urandom_range(3)),
                   ($urandom_range(3) == 0) ? CBW_LENGTH : 10'($urandom_range(1023)),
                   $urandom_range(1) ? CBW_SIGNATURE : 32'($urandom),
                   $urandom, xfer_len, flags, opc,
                   $urandom_range(1) ? iface_type_byte() : 8'($urandom),
                   $urandom_range(1) ? 8'($urandom_range(8'hFE, 8'hFF)) : 8'($urandom));
         left_stuck = 1'b1;
      end
   endtask

   // receiver side: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
         end
      end
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("usb_msc_bulk_only_transport_fsm regression: fail");
      $finish;
   end

   initial begin
      int  start_count;
      bit  hold_done;
      hold_done = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: every action, phase and special case
      send_in();
      send_word(OP_OUT, CBW_LENGTH, CBW_SIGNATURE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF,
                OPC_INQUIRY, 8'h00, 8'h00);
      send_in();
      send_in();
      send_cbw(OPC_RFC, 32'd5, 8'h00);
      send_in();
      send_cbw(OPC_INQUIRY, 32'd36, 8'h80);
      send_setup(8'hA1, REQ_MSC_RESET);
      send_cbw(OPC_SENSE, 32'h0000_1234, 8'h80);
      send_in();
      send_cbw(8'hFF, 32'd0, 8'h00);
      send_in();
      send_cbw(8'h00, 32'd1, 8'h80);
      send_in();
      send_setup(8'h21, REQ_MAX_LUN);
      send_setup(8'h22, REQ_MSC_RESET);
      send_setup(8'h21, 8'h00);
      send_setup(8'hFF, REQ_MSC_RESET);
      send_setup(8'h21, REQ_MSC_RESET);
      send_cbw(OPC_RFC, 32'd0, 8'h80);
      send_in();
      send_in();
      send_word(OP_OUT, 10'h3FF, CBW_SIGNATURE, 32'h0, 32'd8, 8'h80, OPC_INQUIRY,
                8'h00, 8'h00);
      send_setup(8'hA1, REQ_MSC_RESET);
      send_word(OP_OUT, CBW_LENGTH, ~CBW_SIGNATURE, 32'h1, 32'd8, 8'h80, OPC_INQUIRY,
                8'h00, 8'h00);
      send_word(OP_SPARE, 10'h0, 32'h0, 32'h0, 32'h0, 8'h0, 8'h0, 8'h0, 8'h0);
      wait_for_results();

      for (int mix = 0; mix < 4; mix++) begin
         case (mix)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 49;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 49;
            end
            default: begin
               send_idle_pct = 24;
               recv_stall_pct = 24;
            end
         endcase
         start_count = sent_count;
         hold_done = 1'b0;
         while (sent_count - start_count < EVENTS_PER_MIX) begin
            if ((mix == 0 || mix == 3) && !hold_done && sent_count - start_count >= 100) begin
               hold_request = 1'b1;
               hold_done = 1'b1;
            end
            random_flow();
            if ($urandom_range(49) == 0)
               wait_for_results();
         end
         wait_for_results();
      end

      repeat (4) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("usb_msc_bulk_only_transport_fsm regression: pass");
      else
         $display("usb_msc_bulk_only_transport_fsm regression: fail");
      $finish;
   end

endmodule
